### design/bpfq_pkg.sv
// Shared types and constants for the bounded priority frame queue.
package bpfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int ITEM_BYTES_DEF  = 16;
    localparam int MAX_BYTES       = 16;
    localparam int PRI_W           = 8;
    localparam int IN_LEN_W        = 8;
    localparam int LEN_W           = 5;
    localparam int ORD_W           = 32;
    localparam int OCC_W           = 4;
    localparam int PAY_W           = 64;

    typedef enum logic [1:0] {
        FUNC_ENQ = 2'd0,
        FUNC_DEQ = 2'd1,
        FUNC_CLR = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic             urg_vld;
        logic [PRI_W-1:0] urg_pri;
        logic [ORD_W-1:0] urg_ord;
        logic             drp_vld;
        logic [PRI_W-1:0] drp_pri;
        logic [ORD_W-1:0] drp_ord;
        logic             free_vld;
    } t_scan;

    typedef struct packed {
        logic start;
        logic wr_free;
        logic wr_drp;
        logic release_urg;
        logic clear_all;
    } t_cmd;

    typedef struct packed {
        logic urg;
        logic drp;
    } t_claim;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [LEN_W-1:0] len;
        logic [ORD_W-1:0] ord;
    } t_wdata;

endpackage

### design/bpfq_cell.sv
// One frame slot of the queue, passing the running search result to its neighbor.
module bpfq_cell #(
    parameter int DATA_W = 8 * bpfq_pkg::ITEM_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tok,
    input  bpfq_pkg::t_scan             i_scan,
    output logic                        o_tok,
    output bpfq_pkg::t_scan             o_scan,
    input  bpfq_pkg::t_cmd              i_cmd,
    input  bpfq_pkg::t_claim            i_claim_any,
    output bpfq_pkg::t_claim            o_claim,
    input  bpfq_pkg::t_wdata            i_wr,
    input  logic [DATA_W-1:0]           i_wr_data,
    output logic [bpfq_pkg::PRI_W-1:0]  o_sel_pri,
    output logic [bpfq_pkg::LEN_W-1:0]  o_sel_len,
    output logic [DATA_W-1:0]           o_sel_data
);

    logic                       r_tok;
    logic                       r_used;
    logic                       r_is_urg;
    logic                       r_is_drp;
    logic                       r_is_free;
    bpfq_pkg::t_scan            r_scan;
    bpfq_pkg::t_scan            n_scan;
    logic [bpfq_pkg::PRI_W-1:0] r_pri;
    logic [bpfq_pkg::LEN_W-1:0] r_len;
    logic [bpfq_pkg::ORD_W-1:0] r_ord;
    logic [DATA_W-1:0]          r_data;
    bpfq_pkg::t_claim           claim;
    logic                       free_hit;
    logic                       wr_hit;

    always_comb begin
        n_scan   = i_scan;
        claim    = '0;
        free_hit = 1'b0;
        if (i_tok) begin
            if (r_used) begin
                if (!i_scan.urg_vld || r_pri < i_scan.urg_pri ||
                    (r_pri == i_scan.urg_pri && r_ord < i_scan.urg_ord)) begin
                    claim.urg      = 1'b1;
                    n_scan.urg_vld = 1'b1;
                    n_scan.urg_pri = r_pri;
                    n_scan.urg_ord = r_ord;
                end
                if (!i_scan.drp_vld || r_pri > i_scan.drp_pri ||
                    (r_pri == i_scan.drp_pri && r_ord < i_scan.drp_ord)) begin
                    claim.drp      = 1'b1;
                    n_scan.drp_vld = 1'b1;
                    n_scan.drp_pri = r_pri;
                    n_scan.drp_ord = r_ord;
                end
            end else if (!i_scan.free_vld) begin
                free_hit        = 1'b1;
                n_scan.free_vld = 1'b1;
            end
        end
    end

    assign wr_hit = (i_cmd.wr_free && r_is_free) || (i_cmd.wr_drp && r_is_drp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok     <= 1'b0;
            r_used    <= 1'b0;
            r_is_urg  <= 1'b0;
            r_is_drp  <= 1'b0;
            r_is_free <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (claim.urg) begin
                r_is_urg <= 1'b1;
            end else if (i_claim_any.urg || i_cmd.start) begin
                r_is_urg <= 1'b0;
            end
            if (claim.drp) begin
                r_is_drp <= 1'b1;
            end else if (i_claim_any.drp || i_cmd.start) begin
                r_is_drp <= 1'b0;
            end
            if (free_hit) begin
                r_is_free <= 1'b1;
            end else if (i_cmd.start) begin
                r_is_free <= 1'b0;
            end
            priority if (i_cmd.clear_all) begin
                r_used <= 1'b0;
            end else if (wr_hit) begin
                r_used <= 1'b1;
            end else if (i_cmd.release_urg && r_is_urg) begin
                r_used <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_scan <= n_scan;
        end
        if (wr_hit) begin
            r_pri  <= i_wr.pri;
            r_len  <= i_wr.len;
            r_ord  <= i_wr.ord;
            r_data <= i_wr_data;
        end
    end

    assign o_tok      = r_tok;
    assign o_scan     = r_scan;
    assign o_claim    = claim;
    assign o_sel_pri  = r_is_urg ? r_pri : '0;
    assign o_sel_len  = r_is_urg ? r_len : '0;
    assign o_sel_data = r_is_urg ? r_data : '0;

endmodule

### design/bpfq_ctrl.sv
// Sequencer of the queue: input capture, scan start, commit decision and result register.
module bpfq_ctrl #(
    parameter int QUEUE_DEPTH = bpfq_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_BYTES  = bpfq_pkg::ITEM_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_func,
    input  logic [bpfq_pkg::PRI_W-1:0]     i_priority_req,
    input  logic [bpfq_pkg::IN_LEN_W-1:0]  i_length,
    input  logic [bpfq_pkg::PAY_W-1:0]     i_payload_lo,
    input  logic [bpfq_pkg::PAY_W-1:0]     i_payload_hi,
    input  bpfq_pkg::t_scan                i_scan,
    input  logic                           i_done,
    output bpfq_pkg::t_cmd                 o_cmd,
    output bpfq_pkg::t_wdata               o_wr,
    output logic [8*ITEM_BYTES-1:0]        o_wr_data,
    input  logic [bpfq_pkg::PRI_W-1:0]     i_sel_pri,
    input  logic [bpfq_pkg::LEN_W-1:0]     i_sel_len,
    input  logic [8*ITEM_BYTES-1:0]        i_sel_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_ok,
    output logic [bpfq_pkg::PRI_W-1:0]     o_out_priority,
    output logic [bpfq_pkg::LEN_W-1:0]     o_out_length,
    output logic [8*ITEM_BYTES-1:0]        o_out_data,
    output logic [bpfq_pkg::OCC_W-1:0]     o_occupancy
);

    localparam int DATA_W = 8 * ITEM_BYTES;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [bpfq_pkg::IN_LEN_W-1:0] ITEM_LEN = bpfq_pkg::IN_LEN_W'(ITEM_BYTES);

    bpfq_pkg::t_state               r_state;
    bpfq_pkg::t_state               n_state;
    logic                           r_start;
    bpfq_pkg::t_func                r_func;
    logic [bpfq_pkg::PRI_W-1:0]     r_pri;
    logic [bpfq_pkg::LEN_W-1:0]     r_len;
    logic [DATA_W-1:0]              r_data;
    logic [bpfq_pkg::ORD_W-1:0]     r_order;
    logic [FILL_W-1:0]              r_fill;
    logic [FILL_W-1:0]              n_fill;
    logic                           r_out_vld;
    logic                           r_ok;
    logic                           n_ok;
    logic [bpfq_pkg::PRI_W-1:0]     r_o_pri;
    logic [bpfq_pkg::LEN_W-1:0]     r_o_len;
    logic [DATA_W-1:0]              r_o_data;
    logic [bpfq_pkg::OCC_W-1:0]     r_occ;
    logic [bpfq_pkg::LEN_W-1:0]     len_c;
    logic [8*bpfq_pkg::MAX_BYTES-1:0] pay_in;
    logic [8*bpfq_pkg::MAX_BYTES-1:0] pay_mask;
    logic                           accept;
    logic                           can_commit;
    logic                           commit;
    logic                           enq_ok;
    logic                           is_deq;
    bpfq_pkg::t_cmd                 cmd;

    assign accept     = i_valid && (r_state == bpfq_pkg::ST_IDLE);
    assign can_commit = !r_out_vld || !i_stall;

    always_comb begin
        len_c  = (i_length > ITEM_LEN) ? bpfq_pkg::LEN_W'(ITEM_BYTES)
                                       : i_length[bpfq_pkg::LEN_W-1:0];
        pay_in = {i_payload_hi, i_payload_lo};
        for (int b = 0; b < bpfq_pkg::MAX_BYTES; b++) begin
            pay_mask[b*8 +: 8] = (bpfq_pkg::LEN_W'(b) < len_c) ? pay_in[b*8 +: 8] : 8'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpfq_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = bpfq_pkg::ST_SCAN;
                end
            end
            bpfq_pkg::ST_SCAN: begin
                if (i_done) begin
                    n_state = bpfq_pkg::ST_COMMIT;
                end
            end
            bpfq_pkg::ST_COMMIT: begin
                if (can_commit) begin
                    n_state = bpfq_pkg::ST_IDLE;
                end
            end
            default: n_state = bpfq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall   = (r_state != bpfq_pkg::ST_IDLE);
        commit    = (r_state == bpfq_pkg::ST_COMMIT) && can_commit;
        enq_ok    = i_scan.free_vld || (i_scan.drp_vld && r_pri <= i_scan.drp_pri);
        is_deq    = (r_func == bpfq_pkg::FUNC_DEQ);
        cmd       = '0;
        cmd.start = r_start;
        n_ok      = 1'b0;
        n_fill    = r_fill;
        if (commit) begin
            unique case (r_func)
                bpfq_pkg::FUNC_ENQ: begin
                    cmd.wr_free = i_scan.free_vld;
                    cmd.wr_drp  = !i_scan.free_vld && enq_ok;
                    n_ok        = enq_ok;
                    if (i_scan.free_vld) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
                bpfq_pkg::FUNC_DEQ: begin
                    cmd.release_urg = i_scan.urg_vld;
                    n_ok            = i_scan.urg_vld;
                    if (i_scan.urg_vld) begin
                        n_fill = r_fill - FILL_W'(1);
                    end
                end
                bpfq_pkg::FUNC_CLR: begin
                    cmd.clear_all = 1'b1;
                    n_ok          = 1'b1;
                    n_fill        = '0;
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bpfq_pkg::ST_IDLE;
            r_start   <= 1'b0;
            r_order   <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= accept;
            r_fill  <= n_fill;
            if (cmd.wr_free || cmd.wr_drp) begin
                r_order <= r_order + bpfq_pkg::ORD_W'(1);
            end
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= bpfq_pkg::t_func'(i_func);
            r_pri  <= i_priority_req;
            r_len  <= len_c;
            r_data <= pay_mask[DATA_W-1:0];
        end
        if (commit) begin
            r_ok     <= n_ok;
            r_o_pri  <= is_deq ? i_sel_pri : '0;
            r_o_len  <= is_deq ? i_sel_len : '0;
            r_o_data <= is_deq ? i_sel_data : '0;
            r_occ    <= bpfq_pkg::OCC_W'(n_fill);
        end
    end

    assign o_cmd          = cmd;
    assign o_wr.pri       = r_pri;
    assign o_wr.len       = r_len;
    assign o_wr.ord       = r_order;
    assign o_wr_data      = r_data;
    assign o_valid        = r_out_vld;
    assign o_ok           = r_ok;
    assign o_out_priority = r_o_pri;
    assign o_out_length   = r_o_len;
    assign o_out_data     = r_o_data;
    assign o_occupancy    = r_occ;

endmodule

### design/bounded_priority_frame_queue.sv
// Top level of the bounded priority frame queue: sequencer and row of slot cells.
//
// The input channel takes one operation word per handshake: enqueue, dequeue or
// clear, with a priority, a length and up to sixteen payload bytes. The output
// channel returns one result word per operation: the status flag, the dequeued
// frame (zero for anything but a successful dequeue) and the occupancy after
// the operation.
// Each operation passes a search token down the row of QUEUE_DEPTH slot cells,
// one cell per cycle, to find the most urgent entry, the drop candidate and the
// lowest free slot; a commit state then applies the decision. The block takes
// one word at a time: it stalls the input channel until that operation has
// committed its result.
// The block takes the next word while a finished result still sits in the
// output register. If the receiver stalls, that result holds, and a following
// operation completes its scan and then waits to commit until the register
// frees.
// Reset empties the store, zeroes the fill count behind the occupancy and the
// arrival counter, and drops any result not yet taken.
module bounded_priority_frame_queue #(
    parameter int QUEUE_DEPTH = bpfq_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_BYTES  = bpfq_pkg::ITEM_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_func,
    input  logic [bpfq_pkg::PRI_W-1:0]     i_priority_req,
    input  logic [bpfq_pkg::IN_LEN_W-1:0]  i_length,
    input  logic [bpfq_pkg::PAY_W-1:0]     i_payload_lo,
    input  logic [bpfq_pkg::PAY_W-1:0]     i_payload_hi,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_ok,
    output logic [bpfq_pkg::PRI_W-1:0]     o_out_priority,
    output logic [bpfq_pkg::LEN_W-1:0]     o_out_length,
    output logic [bpfq_pkg::PAY_W-1:0]     o_out_payload_lo,
    output logic [bpfq_pkg::PAY_W-1:0]     o_out_payload_hi,
    output logic [bpfq_pkg::OCC_W-1:0]     o_occupancy
);

    localparam int DATA_W = 8 * ITEM_BYTES;

    logic                       tok  [QUEUE_DEPTH+1];
    bpfq_pkg::t_scan            scan [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH-1:0]     claim_urg;
    logic [QUEUE_DEPTH-1:0]     claim_drp;
    bpfq_pkg::t_claim           claim_any;
    bpfq_pkg::t_cmd             cmd;
    bpfq_pkg::t_wdata           wr;
    logic [DATA_W-1:0]          wr_data;
    logic [bpfq_pkg::PRI_W-1:0] cell_pri  [QUEUE_DEPTH];
    logic [bpfq_pkg::LEN_W-1:0] cell_len  [QUEUE_DEPTH];
    logic [DATA_W-1:0]          cell_data [QUEUE_DEPTH];
    logic [bpfq_pkg::PRI_W-1:0] sel_pri;
    logic [bpfq_pkg::LEN_W-1:0] sel_len;
    logic [DATA_W-1:0]          sel_data;
    logic [DATA_W-1:0]          out_data;
    logic [8*bpfq_pkg::MAX_BYTES-1:0] out_wide;

    assign tok[0]        = cmd.start;
    assign scan[0]       = '0;
    assign claim_any.urg = |claim_urg;
    assign claim_any.drp = |claim_drp;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        bpfq_pkg::t_claim claim;

        bpfq_cell #(
            .DATA_W (DATA_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (tok[g]),
            .i_scan      (scan[g]),
            .o_tok       (tok[g+1]),
            .o_scan      (scan[g+1]),
            .i_cmd       (cmd),
            .i_claim_any (claim_any),
            .o_claim     (claim),
            .i_wr        (wr),
            .i_wr_data   (wr_data),
            .o_sel_pri   (cell_pri[g]),
            .o_sel_len   (cell_len[g]),
            .o_sel_data  (cell_data[g])
        );

        assign claim_urg[g] = claim.urg;
        assign claim_drp[g] = claim.drp;
    end

    always_comb begin
        sel_pri  = '0;
        sel_len  = '0;
        sel_data = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            sel_pri  = sel_pri | cell_pri[i];
            sel_len  = sel_len | cell_len[i];
            sel_data = sel_data | cell_data[i];
        end
    end

    bpfq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ITEM_BYTES  (ITEM_BYTES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_priority_req (i_priority_req),
        .i_length       (i_length),
        .i_payload_lo   (i_payload_lo),
        .i_payload_hi   (i_payload_hi),
        .i_scan         (scan[QUEUE_DEPTH]),
        .i_done         (tok[QUEUE_DEPTH]),
        .o_cmd          (cmd),
        .o_wr           (wr),
        .o_wr_data      (wr_data),
        .i_sel_pri      (sel_pri),
        .i_sel_len      (sel_len),
        .i_sel_data     (sel_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_ok           (o_ok),
        .o_out_priority (o_out_priority),
        .o_out_length   (o_out_length),
        .o_out_data     (out_data),
        .o_occupancy    (o_occupancy)
    );

    assign out_wide         = (8*bpfq_pkg::MAX_BYTES)'(out_data);
    assign o_out_payload_lo = out_wide[bpfq_pkg::PAY_W-1:0];
    assign o_out_payload_hi = out_wide[2*bpfq_pkg::PAY_W-1:bpfq_pkg::PAY_W];

endmodule

### design/bpfq_checker.sv
// Port-level checks for the bounded priority frame queue, bound to the top level.
module bpfq_checker #(
    parameter int ITEM_BYTES = bpfq_pkg::ITEM_BYTES_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic                           o_ok,
    input logic [bpfq_pkg::PRI_W-1:0]     o_out_priority,
    input logic [bpfq_pkg::LEN_W-1:0]     o_out_length,
    input logic [bpfq_pkg::PAY_W-1:0]     o_out_payload_lo,
    input logic [bpfq_pkg::PAY_W-1:0]     o_out_payload_hi
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ok) && $stable(o_out_length)
                               && $stable(o_out_payload_lo))
        else $error("Stalled result word changed.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Second word taken while an operation is in progress.");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_out_priority == '0 && o_out_length == '0
                             && o_out_payload_lo == '0 && o_out_payload_hi == '0)
        else $error("Failed operation returned frame fields.");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_length <= bpfq_pkg::LEN_W'(ITEM_BYTES))
        else $error("Returned length exceeds the item size.");

endmodule

bind bounded_priority_frame_queue bpfq_checker #(
    .ITEM_BYTES (ITEM_BYTES)
) u_bpfq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_ok             (o_ok),
    .o_out_priority   (o_out_priority),
    .o_out_length     (o_out_length),
    .o_out_payload_lo (o_out_payload_lo),
    .o_out_payload_hi (o_out_payload_hi)
);

### sim/bpfq_checker.sv
// Checker for the bounded priority frame queue: predicts each result word and compares it.
module bpfq_scoreboard
    import bpfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ITEM_BYTES  = ITEM_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    input  logic                i_op_stall,
    input  logic [1:0]          i_func,
    input  logic [PRI_W-1:0]    i_priority_req,
    input  logic [IN_LEN_W-1:0] i_length,
    input  logic [PAY_W-1:0]    i_payload_lo,
    input  logic [PAY_W-1:0]    i_payload_hi,
    input  logic                i_res_valid,
    input  logic                i_res_stall,
    input  logic                i_ok,
    input  logic [PRI_W-1:0]    i_out_priority,
    input  logic [LEN_W-1:0]    i_out_length,
    input  logic [PAY_W-1:0]    i_out_payload_lo,
    input  logic [PAY_W-1:0]    i_out_payload_hi,
    input  logic [OCC_W-1:0]    i_occupancy,
    output int                  o_mismatch_count,
    output int                  o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             ok;
        logic [PRI_W-1:0] pri;
        logic [LEN_W-1:0] len;
        logic [PAY_W-1:0] lo;
        logic [PAY_W-1:0] hi;
        logic [OCC_W-1:0] occ;
    } t_result_word;

    logic             slot_busy [QUEUE_DEPTH];
    logic [PRI_W-1:0] slot_pri  [QUEUE_DEPTH];
    logic [LEN_W-1:0] slot_len  [QUEUE_DEPTH];
    logic [PAY_W-1:0] slot_lo   [QUEUE_DEPTH];
    logic [PAY_W-1:0] slot_hi   [QUEUE_DEPTH];
    logic [ORD_W-1:0] slot_seq  [QUEUE_DEPTH];
    logic [ORD_W-1:0] seq_next;
    int unsigned      frames_held;
    t_result_word     awaited [$];

    function automatic logic [PAY_W-1:0] low_bytes(input int n);
        if (n >= 8) begin
            return '1;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic t_result_word run_operation(
        input logic [1:0]          func,
        input logic [PRI_W-1:0]    pri,
        input logic [IN_LEN_W-1:0] len,
        input logic [PAY_W-1:0]    lo,
        input logic [PAY_W-1:0]    hi
    );
        t_result_word r;
        int           keep;
        int           pick;
        logic [PAY_W-1:0] mlo;
        logic [PAY_W-1:0] mhi;
        r = '0;
        pick = -1;
        case (func)
            FUNC_ENQ: begin
                keep = (int'(len) > ITEM_BYTES) ? ITEM_BYTES : int'(len);
                mlo = lo & low_bytes(keep);
                mhi = (keep > 8) ? (hi & low_bytes(keep - 8)) : '0;
                if (frames_held < QUEUE_DEPTH) begin
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        if (!slot_busy[i] && pick < 0) begin
                            pick = i;
                        end
                    end
                    if (pick >= 0) begin
                        frames_held++;
                    end
                end else begin
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        if (slot_busy[i] && (pick < 0 || slot_pri[i] > slot_pri[pick] ||
                            (slot_pri[i] == slot_pri[pick] && slot_seq[i] < slot_seq[pick])))
                        begin
                            pick = i;
                        end
                    end
                    if (pick >= 0 && pri > slot_pri[pick]) begin
                        pick = -1;
                    end
                end
                if (pick >= 0) begin
                    slot_busy[pick] = 1'b1;
                    slot_pri[pick]  = pri;
                    slot_len[pick]  = LEN_W'(keep);
                    slot_lo[pick]   = mlo;
                    slot_hi[pick]   = mhi;
                    slot_seq[pick]  = seq_next;
                    seq_next        = seq_next + 1'b1;
                    r.ok            = 1'b1;
                end
            end
            FUNC_DEQ: begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (slot_busy[i] && (pick < 0 || slot_pri[i] < slot_pri[pick] ||
                        (slot_pri[i] == slot_pri[pick] && slot_seq[i] < slot_seq[pick])))
                    begin
                        pick = i;
                    end
                end
                if (pick >= 0) begin
                    r.ok  = 1'b1;
                    r.pri = slot_pri[pick];
                    r.len = slot_len[pick];
                    r.lo  = slot_lo[pick];
                    r.hi  = slot_hi[pick];
                    slot_busy[pick] = 1'b0;
                    if (frames_held > 0) begin
                        frames_held--;
                    end
                end
            end
            FUNC_CLR: begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    slot_busy[i] = 1'b0;
                end
                frames_held = 0;
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        r.occ = OCC_W'(frames_held);
        return r;
    endfunction

    initial begin
        o_mismatch_count = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        t_result_word seen;
        t_result_word wanted;
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                slot_busy[i] = 1'b0;
            end
            frames_held = 0;
            seq_next = '0;
            awaited.delete();
        end else begin
            if (i_op_valid && !i_op_stall) begin
                awaited.push_back(run_operation(i_func, i_priority_req, i_length,
                                                i_payload_lo, i_payload_hi));
            end
            if (i_res_valid && !i_res_stall) begin
                seen = {i_ok, i_out_priority, i_out_length, i_out_payload_lo,
                        i_out_payload_hi, i_occupancy};
                if (awaited.size() == 0) begin
                    o_mismatch_count++;
                    if (o_mismatch_count <= 10) begin
                        $display("%0t: unexpected word ok=%0b pri=%0d len=%0d",
                                 $realtime, seen.ok, seen.pri, seen.len);
                        $display("%0t:   lo=%h hi=%h occ=%0d",
                                 $realtime, seen.lo, seen.hi, seen.occ);
                    end
                end else begin
                    wanted = awaited.pop_front();
                    if (seen !== wanted) begin
                        o_mismatch_count++;
                        if (o_mismatch_count <= 10) begin
                            $display("%0t: expected ok=%0b pri=%0d len=%0d lo=%h hi=%h occ=%0d",
                                     $realtime, wanted.ok, wanted.pri, wanted.len,
                                     wanted.lo, wanted.hi, wanted.occ);
                            $display("%0t:      got ok=%0b pri=%0d len=%0d lo=%h hi=%h occ=%0d",
                                     $realtime, seen.ok, seen.pri, seen.len,
                                     seen.lo, seen.hi, seen.occ);
                        end
                    end
                end
            end
        end
        o_outstanding = awaited.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top for the bounded priority frame queue: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfq_pkg::*;

    localparam int         DEPTH         = QUEUE_DEPTH_DEF;
    localparam int         BYTES         = ITEM_BYTES_DEF;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam int         RANDOM_WORDS  = 1750;
    localparam int         HOLD_AT       = 400;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         PAUSE_AT      = 1100;
    localparam int         SETTLE_CYCLES = 4 * (DEPTH + 3);

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                op_valid       = 1'b0;
    logic                op_stall;
    logic [1:0]          op_func        = FUNC_ENQ;
    logic [PRI_W-1:0]    op_priority    = '0;
    logic [IN_LEN_W-1:0] op_length      = '0;
    logic [PAY_W-1:0]    op_payload_lo  = '0;
    logic [PAY_W-1:0]    op_payload_hi  = '0;
    logic                res_valid;
    logic                res_stall      = 1'b0;
    logic                res_ok;
    logic [PRI_W-1:0]    res_priority;
    logic [LEN_W-1:0]    res_length;
    logic [PAY_W-1:0]    res_payload_lo;
    logic [PAY_W-1:0]    res_payload_hi;
    logic [OCC_W-1:0]    res_occupancy;
    int                  mismatches;
    int                  outstanding;
    bit                  hold_request   = 1'b0;
    int unsigned         n_enq          = 0;
    int unsigned         n_deq          = 0;
    int unsigned         n_clr          = 0;
    int unsigned         n_unused       = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bounded_priority_frame_queue #(
        .QUEUE_DEPTH(DEPTH),
        .ITEM_BYTES (BYTES)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (op_valid),
        .o_stall         (op_stall),
        .i_func          (op_func),
        .i_priority_req  (op_priority),
        .i_length        (op_length),
        .i_payload_lo    (op_payload_lo),
        .i_payload_hi    (op_payload_hi),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_ok            (res_ok),
        .o_out_priority  (res_priority),
        .o_out_length    (res_length),
        .o_out_payload_lo(res_payload_lo),
        .o_out_payload_hi(res_payload_hi),
        .o_occupancy     (res_occupancy)
    );

    bpfq_scoreboard #(
        .QUEUE_DEPTH(DEPTH),
        .ITEM_BYTES (BYTES)
    ) i_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_op_valid      (op_valid),
        .i_op_stall      (op_stall),
        .i_func          (op_func),
        .i_priority_req  (op_priority),
        .i_length        (op_length),
        .i_payload_lo    (op_payload_lo),
        .i_payload_hi    (op_payload_hi),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_ok            (res_ok),
        .i_out_priority  (res_priority),
        .i_out_length    (res_length),
        .i_out_payload_lo(res_payload_lo),
        .i_out_payload_hi(res_payload_hi),
        .i_occupancy     (res_occupancy),
        .o_mismatch_count(mismatches),
        .o_outstanding   (outstanding)
    );

    task automatic send_op(
        input logic [1:0]          func,
        input logic [PRI_W-1:0]    pri,
        input logic [IN_LEN_W-1:0] len,
        input logic [PAY_W-1:0]    lo,
        input logic [PAY_W-1:0]    hi,
        input int                  gap
    );
        if (gap > 0) begin
            op_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_valid      <= 1'b1;
        op_func       <= func;
        op_priority   <= pri;
        op_length     <= len;
        op_payload_lo <= lo;
        op_payload_hi <= hi;
        do @(posedge clk); while (op_stall);
        case (func)
            FUNC_ENQ: n_enq++;
            FUNC_DEQ: n_deq++;
            FUNC_CLR: n_clr++;
            default:  n_unused++;
        endcase
    endtask

    initial begin : rx_side
        int open_left;
        int stall_left;
        int r;
        open_left = 0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_stall <= 1'b1;
            end else if (open_left > 0) begin
                open_left--;
                res_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    open_left = $urandom_range(40, 200);
                    stall_left = 0;
                end else if (r == 1) begin
                    open_left = $urandom_range(0, 4);
                    stall_left = $urandom_range(15, 80);
                end else begin
                    open_left = $urandom_range(0, 6);
                    stall_left = $urandom_range(0, 3);
                end
                res_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int                  fill_pri [8];
        int                  fill_len [8];
        int                  k;
        int                  r;
        int                  block_len;
        int                  enq_pct;
        int                  gap;
        int                  burst_left;
        bit                  narrow;
        bit                  quiet;
        logic [PRI_W-1:0]    base;
        logic [PRI_W-1:0]    pri;
        logic [IN_LEN_W-1:0] len;
        logic [1:0]          func;
        fill_pri = '{200, 0, 7, 7, 7, 128, 100, 200};
        fill_len = '{255, 0, 8, 9, 1, 16, 15, 7};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(FUNC_DEQ, '0, '0, '1, '1, 0);
        send_op(FUNC_UNUSED, '1, '1, '1, '1, 1);
        for (int i = 0; i < 8; i++) begin
            send_op(FUNC_ENQ, PRI_W'(fill_pri[i]), IN_LEN_W'(fill_len[i]), '1, '1,
                    $urandom_range(0, 2));
        end
        send_op(FUNC_ENQ, 8'd201, 8'd16, {$urandom, $urandom}, {$urandom, $urandom}, 0);
        send_op(FUNC_ENQ, 8'd200, 8'd12, '1, '1, 0);
        send_op(FUNC_ENQ, 8'hFF, 8'd16, '1, '1, 0);
        send_op(FUNC_UNUSED, '0, '0, '0, '0, 0);
        repeat (3) send_op(FUNC_DEQ, '0, '0, '0, '0, $urandom_range(0, 2));
        send_op(FUNC_CLR, '0, '0, '0, '0, 0);
        send_op(FUNC_DEQ, '0, '0, '0, '0, 0);
        send_op(FUNC_ENQ, 8'hFF, 8'hFF, '1, '1, 0);
        send_op(FUNC_ENQ, 8'h00, 8'd16, '0, '0, 0);
        repeat (2) send_op(FUNC_DEQ, '1, '1, '1, '1, 0);

        k = 0;
        burst_left = 0;
        while (k < RANDOM_WORDS) begin
            block_len = $urandom_range(20, 60);
            r = $urandom_range(0, 2);
            enq_pct = (r == 0) ? 80 : (r == 1) ? 30 : 55;
            narrow = $urandom_range(0, 1);
            quiet = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 3);
            base = (r == 0) ? 8'd0 : (r == 1) ? 8'd252 : PRI_W'($urandom_range(0, 252));
            repeat (block_len) begin
                if (k == HOLD_AT) begin
                    hold_request = 1'b1;
                    burst_left = 30;
                end
                if (k == PAUSE_AT) begin
                    op_valid <= 1'b0;
                    @(posedge clk);
                    wait (outstanding == 0);
                    @(posedge clk);
                end
                r = $urandom_range(0, 99);
                func = (r < 2) ? FUNC_CLR : (r < 4) ? FUNC_UNUSED :
                       (r < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
                pri = narrow ? base + PRI_W'($urandom_range(0, 3))
                             : PRI_W'($urandom_range(0, 255));
                len = ($urandom_range(0, 4) == 0) ? IN_LEN_W'($urandom_range(0, 255))
                                                   : IN_LEN_W'($urandom_range(0, 16));
                r = $urandom_range(0, 9);
                if (quiet || burst_left > 0 || r < 6) begin
                    gap = 0;
                end else if (r < 9) begin
                    gap = $urandom_range(1, 3);
                end else begin
                    gap = $urandom_range(8, 40);
                end
                if (burst_left > 0) begin
                    burst_left--;
                end
                send_op(func, pri, len, {$urandom, $urandom}, {$urandom, $urandom}, gap);
                k++;
            end
        end

        op_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d operation words: %0d enqueue, %0d dequeue, %0d clear,",
                 n_enq + n_deq + n_clr + n_unused, n_enq, n_deq, n_clr);
        $display("%0d unused code, with random stalls on both channels,", n_unused);
        $display("a %0d-cycle receiver hold and a drain pause.", HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

### bounded_priority_frame_queue.f
design/bpfq_pkg.sv
design/bpfq_cell.sv
design/bpfq_ctrl.sv
design/bounded_priority_frame_queue.sv
design/bpfq_checker.sv
sim/bpfq_checker.sv
sim/tb_top.sv
